>>> hdl/spm_pkg.sv
// Shared types, character codes and bit helpers for the symbolic permission
// mode parser. No dependencies; used by spm_step and the top level.
package spm_pkg;

    localparam logic [11:0] MASK_RESET = 12'o022;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_SET = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_XCAP  = 8'h58;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [11:0] USER_BITS  = 12'o4700;
    localparam logic [11:0] GROUP_BITS = 12'o2070;
    localparam logic [11:0] OTHER_BITS = 12'o1007;
    localparam logic [11:0] EXEC_BITS  = 12'o0111;
    localparam logic [11:0] SETUID_BIT = 12'o4000;
    localparam logic [11:0] SETGID_BIT = 12'o2000;
    localparam logic [11:0] STICKY_BIT = 12'o1000;

    typedef struct packed {
        logic        perm;       // 1: permission letters phase
        logic [2:0]  class_set;  // bit0 u, bit1 g, bit2 o
        logic        explicit;
        logic [1:0]  op;
        logic [11:0] clause;
        logic [11:0] run;
        logic [11:0] start;
        logic        dir;
        logic        err;
    } spm_state_t;

    function automatic logic [11:0] spread(input logic [2:0] triad, input logic [2:0] who);
        logic [11:0] r;
        r = '0;
        if (who[0]) r = r | {3'b000, triad, 6'b000000};
        if (who[1]) r = r | {6'b000000, triad, 3'b000};
        if (who[2]) r = r | {9'b000000000, triad};
        return r;
    endfunction

    function automatic logic [11:0] affected(input logic [2:0] who);
        logic [11:0] m;
        m = '0;
        if (who[0]) m = m | USER_BITS;
        if (who[1]) m = m | GROUP_BITS;
        if (who[2]) m = m | OTHER_BITS;
        return m;
    endfunction

endpackage

>>> hdl/symbolic_permission_mode_parser_core.sv
// Top level of the symbolic permission mode parser: input register, parse
// state, creation mask register and result register. Depends on spm_pkg, spm_step.
//
//  channel   direction  payload                                      completes when
//  s_*       in         tdata char/mode/dir, tuser first, tlast       s_tvalid & s_tready
//  m_*       out        tdata new_mode/valid_res                      m_tvalid & m_tready
//  cfg_*     in         cfg_data creation_mask                        cfg_valid & cfg_ready
//
// One character per cycle unless a last character waits on a pending result: a
// character passes through the input register, then updates the parse state;
// the last character loads the result register, which drives m_tvalid.
// Reset clears the parse state, the running mode and sets creation_mask to 0o022.
// A stalled result holds only a last character in the input register;
// other characters keep flowing while the result waits.
module symbolic_permission_mode_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] character, [19:8] original_mode,
                                   // [20] is_directory, [23:21] zero
    input  logic        s_tuser,   // [0] first
    input  logic        s_tlast,   // last character of the string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] new_mode, [12] valid_res, [15:13] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    import spm_pkg::*;

    logic        stg_valid_reg;
    logic [7:0]  stg_char_reg;
    logic        stg_first_reg;
    logic        stg_last_reg;
    logic [11:0] stg_mode_reg;
    logic        stg_dir_reg;

    spm_state_t  st_reg;
    spm_state_t  st_next;
    logic [11:0] mask_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [11:0] out_mode_reg;
    logic        out_ok_reg;
    logic [11:0] res_mode;
    logic        res_ok;

    logic        out_free;
    logic        stg_adv;
    logic        out_load;

    assign out_free  = !out_valid_reg || m_tready;
    assign stg_adv   = stg_valid_reg && (!stg_last_reg || out_free);
    assign out_load  = stg_adv && stg_last_reg;
    assign s_tready  = !stg_valid_reg || stg_adv;
    assign cfg_ready = 1'b1;

    spm_step u_step (
        .cur           (st_reg),
        .character     (stg_char_reg),
        .first         (stg_first_reg),
        .last          (stg_last_reg),
        .original_mode (stg_mode_reg),
        .is_directory  (stg_dir_reg),
        .creation_mask (mask_reg),
        .nxt           (st_next),
        .new_mode      (res_mode),
        .valid_res     (res_ok)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            mask_reg      <= MASK_RESET;
        end
        else
        begin
            if (s_tready)
                stg_valid_reg <= s_tvalid;
            if (stg_adv)
                st_reg <= st_next;
            if (cfg_valid && cfg_ready)
                mask_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            stg_char_reg  <= s_tdata[7:0];
            stg_mode_reg  <= s_tdata[19:8];
            stg_dir_reg   <= s_tdata[20];
            stg_first_reg <= s_tuser;
            stg_last_reg  <= s_tlast;
        end
        if (out_load)
        begin
            out_mode_reg <= res_mode;
            out_ok_reg   <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_ok_reg, out_mode_reg};

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ok_reg || out_mode_reg == 12'h000))
        else $error("invalid result carries a nonzero mode");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register loaded while a result is pending");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!st_reg.err && !st_reg.perm && st_reg.clause == 12'h000))
        else $error("parse state not cleared after last character");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (stg_valid_reg && stg_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a pending result");
`endif

endmodule

>>> hdl/spm_step.sv
// Next-state and result logic for one character of a symbolic mode string.
// Depends on spm_pkg.
module spm_step (
    input  spm_pkg::spm_state_t cur,
    input  logic [7:0]          character,
    input  logic                first,
    input  logic                last,
    input  logic [11:0]         original_mode,
    input  logic                is_directory,
    input  logic [11:0]         creation_mask,
    output spm_pkg::spm_state_t nxt,
    output logic [11:0]         new_mode,
    output logic                valid_res
);
    import spm_pkg::*;

    spm_state_t  s;
    logic        comma_hit;
    logic        do_apply;
    logic        bad;
    logic [11:0] b;
    logic [11:0] applied;

    always_comb
    begin
        s = cur;
        comma_hit = 1'b0;
        if (first)
        begin
            s.start     = original_mode;
            s.run       = original_mode;
            s.dir       = is_directory;
            s.err       = 1'b0;
            s.perm      = 1'b0;
            s.class_set = '0;
            s.explicit  = 1'b0;
            s.op        = OP_ADD;
            s.clause    = '0;
        end

        if (!s.err)
        begin
            if (!s.perm)
            begin
                unique case (character)
                    CH_U:
                    begin
                        s.class_set[0] = 1'b1;
                        s.explicit     = 1'b1;
                    end
                    CH_G:
                    begin
                        s.class_set[1] = 1'b1;
                        s.explicit     = 1'b1;
                    end
                    CH_O:
                    begin
                        s.class_set[2] = 1'b1;
                        s.explicit     = 1'b1;
                    end
                    CH_A:
                    begin
                        s.class_set = 3'b111;
                        s.explicit  = 1'b1;
                    end
                    CH_PLUS, CH_MINUS, CH_EQ:
                    begin
                        s.op = (character == CH_PLUS) ? OP_ADD :
                               (character == CH_MINUS) ? OP_SUB : OP_SET;
                        if (s.class_set == 3'b000) s.class_set = 3'b111;
                        s.clause = '0;
                        s.perm   = 1'b1;
                    end
                    default: s.err = 1'b1;
                endcase
            end
            else
            begin
                unique case (character)
                    CH_COMMA: comma_hit = 1'b1;
                    CH_R:     s.clause = s.clause | spread(3'b100, s.class_set);
                    CH_W:     s.clause = s.clause | spread(3'b010, s.class_set);
                    CH_X:     s.clause = s.clause | spread(3'b001, s.class_set);
                    CH_XCAP:
                    begin
                        if (s.dir || ((s.start & EXEC_BITS) != '0))
                            s.clause = s.clause | spread(3'b001, s.class_set);
                    end
                    CH_S:
                    begin
                        if (s.class_set[0]) s.clause = s.clause | SETUID_BIT;
                        if (s.class_set[1]) s.clause = s.clause | SETGID_BIT;
                    end
                    CH_T:
                    begin
                        if (s.class_set[2]) s.clause = s.clause | STICKY_BIT;
                    end
                    CH_U:     s.clause = s.clause | spread(s.run[8:6], s.class_set);
                    CH_G:     s.clause = s.clause | spread(s.run[5:3], s.class_set);
                    CH_O:     s.clause = s.clause | spread(s.run[2:0], s.class_set);
                    default:  s.err = 1'b1;
                endcase
            end
        end

        // clause applies on its comma, or at the end of a well-formed string
        do_apply = comma_hit || (last && !s.err && s.perm);
        b = s.explicit ? s.clause : (s.clause & ~creation_mask);
        unique case (s.op)
            OP_ADD:  applied = s.run | b;
            OP_SUB:  applied = s.run & ~b;
            default: applied = (s.run & ~affected(s.class_set)) | b;
        endcase
        if (do_apply) s.run = applied;

        if (comma_hit)
        begin
            s.perm      = 1'b0;
            s.class_set = '0;
            s.explicit  = 1'b0;
            s.op        = OP_ADD;
            s.clause    = '0;
        end

        bad       = s.err || !s.perm;
        new_mode  = bad ? 12'h000 : s.run;
        valid_res = !bad;

        if (last)
        begin
            s.err       = 1'b0;
            s.perm      = 1'b0;
            s.class_set = '0;
            s.explicit  = 1'b0;
            s.op        = OP_ADD;
            s.clause    = '0;
        end
        nxt = s;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for symbolic_permission_mode_parser_core: streams mode strings,
// predicts each new mode in a local parser and checks every result transaction.
// Depends on spm_pkg and the parser core RTL.
module tb;
    import spm_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_STALL  = 100;
    localparam int PHASE_CHARS = 210;

    typedef struct {
        logic [7:0]  ch;
        logic        first;
        logic        last;
        logic [11:0] mode;
        logic        dir;
    } char_item_t;

    typedef struct {
        logic [11:0] mode;
        logic        ok;
    } mode_result_t;

    typedef struct {
        logic        in_perm;
        logic [2:0]  who;
        logic        named;
        logic [1:0]  op;
        logic [11:0] clause;
        logic [11:0] run;
        logic [11:0] start;
        logic        dir;
        logic        bad;
    } parse_state_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data  = '0;

    char_item_t   char_queue[$];
    mode_result_t mode_results[$];
    logic [7:0]   spell[$];

    parse_state_t pm      = '{default: '0};
    logic [11:0]  pm_mask = MASK_RESET;

    logic s_took     = 1'b0;
    logic calm       = 1'b0;
    int   chars_queued   = 0;
    int   chars_accepted = 0;
    int   results_seen   = 0;
    int   mismatches     = 0;
    int   quiet_cycles   = 0;
    int   src_gap        = 0;
    int   sink_stall     = 0;
    logic long_done      = 1'b0;

    symbolic_permission_mode_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- mode predictor ----------------

    function automatic logic [11:0] triad_bits(input logic [2:0] triad, input logic [2:0] who);
        logic [11:0] r;
        r = '0;
        for (int k = 0; k < 3; k++)
            if (who[k])
                r = r | ({9'd0, triad} << (6 - 3 * k));
        return r;
    endfunction

    function automatic logic [11:0] class_field(input logic [2:0] who);
        logic [11:0] r;
        r = triad_bits(3'b111, who);
        if (who[0])
            r = r | SETUID_BIT;
        if (who[1])
            r = r | SETGID_BIT;
        if (who[2])
            r = r | STICKY_BIT;
        return r;
    endfunction

    task automatic end_clause();
        pm.in_perm = 1'b0;
        pm.who     = 3'b000;
        pm.named   = 1'b0;
        pm.op      = OP_ADD;
        pm.clause  = '0;
    endtask

    task automatic fold_clause();
        logic [11:0] b;
        b = pm.clause;
        if (!pm.named)
            b = b & ~pm_mask;
        if (pm.op == OP_ADD)
            pm.run = pm.run | b;
        else if (pm.op == OP_SUB)
            pm.run = pm.run & ~b;
        else
            pm.run = (pm.run & ~class_field(pm.who)) | b;
    endtask

    task automatic parse_char(input char_item_t it);
        logic [2:0]   w;
        mode_result_t res;
        if (it.first)
        begin
            pm.start = it.mode;
            pm.run   = it.mode;
            pm.dir   = it.dir;
            pm.bad   = 1'b0;
            end_clause();
        end
        w = pm.who;
        if (!pm.bad && pm.in_perm)
        begin
            case (it.ch)
                CH_COMMA:
                begin
                    fold_clause();
                    end_clause();
                end
                CH_R:    pm.clause = pm.clause | triad_bits(3'b100, w);
                CH_W:    pm.clause = pm.clause | triad_bits(3'b010, w);
                CH_X:    pm.clause = pm.clause | triad_bits(3'b001, w);
                CH_XCAP:
                    if (pm.dir || (pm.start & EXEC_BITS) != '0)
                        pm.clause = pm.clause | triad_bits(3'b001, w);
                CH_S:
                begin
                    if (w[0])
                        pm.clause = pm.clause | SETUID_BIT;
                    if (w[1])
                        pm.clause = pm.clause | SETGID_BIT;
                end
                CH_T:
                    if (w[2])
                        pm.clause = pm.clause | STICKY_BIT;
                CH_U:    pm.clause = pm.clause | triad_bits(pm.run[8:6], w);
                CH_G:    pm.clause = pm.clause | triad_bits(pm.run[5:3], w);
                CH_O:    pm.clause = pm.clause | triad_bits(pm.run[2:0], w);
                default: pm.bad = 1'b1;
            endcase
        end
        else if (!pm.bad)
        begin
            case (it.ch)
                CH_U:
                begin
                    pm.who[0] = 1'b1;
                    pm.named  = 1'b1;
                end
                CH_G:
                begin
                    pm.who[1] = 1'b1;
                    pm.named  = 1'b1;
                end
                CH_O:
                begin
                    pm.who[2] = 1'b1;
                    pm.named  = 1'b1;
                end
                CH_A:
                begin
                    pm.who   = 3'b111;
                    pm.named = 1'b1;
                end
                CH_PLUS, CH_MINUS, CH_EQ:
                begin
                    pm.op = (it.ch == CH_PLUS) ? OP_ADD : (it.ch == CH_MINUS) ? OP_SUB : OP_SET;
                    if (pm.who == 3'b000)
                        pm.who = 3'b111;
                    pm.clause  = '0;
                    pm.in_perm = 1'b1;
                end
                default: pm.bad = 1'b1;
            endcase
        end
        if (it.last)
        begin
            if (!pm.bad)
            begin
                if (pm.in_perm)
                    fold_clause();
                else
                    pm.bad = 1'b1;
            end
            res.mode = pm.bad ? 12'd0 : pm.run;
            res.ok   = !pm.bad;
            mode_results.push_back(res);
            pm.bad = 1'b0;
            end_clause();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] want);
        $display("%0t mismatch on %s: got %o expected %o", $time, what, got, want);
        mismatches++;
    endtask

    // ---------------- driver, sink, monitor ----------------

    always @(negedge clk)
    begin : drive_chars
        char_item_t nxt;
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (char_queue.size() == 0)
                s_tvalid <= 1'b0;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end
            else
            begin
                nxt = char_queue.pop_front();
                s_tdata  <= {3'b000, nxt.dir, nxt.mode, nxt.ch};
                s_tuser  <= nxt.first;
                s_tlast  <= nxt.last;
                s_tvalid <= 1'b1;
            end
        end
    end

    // long hold-off once, after a few results, while the sender keeps going
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else if (!long_done && results_seen >= 25)
        begin
            long_done = 1'b1;
            sink_stall = LONG_STALL - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            sink_stall = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        char_item_t   got_in;
        mode_result_t want;
        if (rst_n)
        begin
            s_took <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                pm_mask = cfg_data;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (mode_results.size() == 0)
                    flag_mismatch("unexpected result", m_tdata[11:0], 12'd0);
                else
                begin
                    want = mode_results.pop_front();
                    if (m_tdata[11:0] != want.mode)
                        flag_mismatch("new_mode", m_tdata[11:0], want.mode);
                    if (m_tdata[12] != want.ok)
                        flag_mismatch("valid_res", {11'd0, m_tdata[12]}, {11'd0, want.ok});
                end
            end
            if (s_tvalid && s_tready)
            begin
                got_in.ch    = s_tdata[7:0];
                got_in.mode  = s_tdata[19:8];
                got_in.dir   = s_tdata[20];
                got_in.first = s_tuser;
                got_in.last  = s_tlast;
                parse_char(got_in);
                chars_accepted++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic spell_text(input string s);
        spell.delete();
        for (int i = 0; i < s.len(); i++)
            spell.push_back(s[i]);
    endtask

    task automatic queue_spell(input logic with_first, input logic [11:0] mode, input logic dir);
        char_item_t it;
        for (int i = 0; i < spell.size(); i++)
        begin
            it.ch    = spell[i];
            it.first = with_first && (i == 0);
            it.last  = (i == spell.size() - 1);
            it.mode  = (i == 0) ? mode : 12'($urandom);
            it.dir   = (i == 0) ? dir : 1'($urandom);
            char_queue.push_back(it);
            chars_queued++;
        end
    endtask

    function automatic logic [7:0] pick_class(input int k);
        case (k)
            0:       return CH_U;
            1:       return CH_G;
            2:       return CH_O;
            default: return CH_A;
        endcase
    endfunction

    function automatic logic [7:0] pick_op(input int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            default: return CH_EQ;
        endcase
    endfunction

    function automatic logic [7:0] pick_perm(input int k);
        case (k)
            0:       return CH_R;
            1:       return CH_W;
            2:       return CH_X;
            3:       return CH_XCAP;
            4:       return CH_S;
            5:       return CH_T;
            6:       return CH_U;
            7:       return CH_G;
            default: return CH_O;
        endcase
    endfunction

    // mostly well-formed clause lists; a few get a stray byte, a stray operator,
    // a trailing comma or a dropped character
    task automatic queue_random_string();
        int          n;
        logic [11:0] mode;
        spell.delete();
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
                spell.push_back(CH_COMMA);
            repeat ($urandom_range(0, 3))
                spell.push_back(pick_class($urandom_range(0, 3)));
            spell.push_back(pick_op($urandom_range(0, 2)));
            repeat ($urandom_range(0, 4))
                spell.push_back(pick_perm($urandom_range(0, 8)));
        end
        case ($urandom_range(0, 19))
            0: spell.insert($urandom_range(0, spell.size()), 8'($urandom_range(0, 255)));
            1: spell.insert($urandom_range(0, spell.size()), pick_op($urandom_range(0, 2)));
            2: spell.push_back(CH_COMMA);
            3:
                if (spell.size() > 1)
                    spell.delete($urandom_range(0, spell.size() - 1));
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0:       mode = 12'd0;
            1:       mode = 12'o7777;
            2:       mode = 12'($urandom) & ~EXEC_BITS;
            default: mode = 12'($urandom);
        endcase
        queue_spell($urandom_range(0, 15) != 0, mode, $urandom_range(0, 3) == 0);
    endtask

    task automatic wait_drained();
        while (!(chars_accepted == chars_queued && mode_results.size() == 0))
            @(negedge clk);
    endtask

    task automatic load_mask(input logic [11:0] value);
        wait_drained();
        repeat (5) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          target;
        logic [11:0] mask_value;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        spell_text("+X");
        queue_spell(1'b1, 12'o0000, 1'b1);
        spell_text("g-s,o=t");
        queue_spell(1'b1, 12'o7777, 1'b0);
        spell_text("=");
        queue_spell(1'b1, 12'o7777, 1'b0);
        spell.delete();
        spell.push_back(8'h00);
        queue_spell(1'b1, 12'o0755, 1'b0);
        spell_text("u+");
        spell.push_back(8'hFF);
        queue_spell(1'b1, 12'o0644, 1'b0);
        spell_text("u");
        queue_spell(1'b1, 12'o0644, 1'b0);
        spell_text("u,");
        queue_spell(1'b1, 12'o0644, 1'b0);
        spell_text("+-");
        queue_spell(1'b1, 12'o0644, 1'b0);
        spell_text("+r,");
        queue_spell(1'b1, 12'o0000, 1'b0);
        spell_text("o=u");
        queue_spell(1'b0, 12'($urandom), 1'b1);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       mask_value = 12'o0000;
                1:       mask_value = 12'o7777;
                3:       mask_value = MASK_RESET;
                default: mask_value = 12'($urandom);
            endcase
            load_mask(mask_value);
            if (ph == 4)
                calm = 1'b1;
            target = chars_queued + PHASE_CHARS;
            while (chars_queued < target)
                queue_random_string();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && mode_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
